>>> design/ttc_pkg.sv
// ttc_pkg: widths, codes and job types shared by the triangle tile coverage block
// no dependencies; used by every module of the block through scoped names
`default_nettype none

package ttc_pkg;

   localparam int COORD_W     = 13;
   localparam int DIFF_W      = 15;
   localparam int EDGE_W      = 2 * DIFF_W;
   localparam int NUM_EDGES   = 3;
   localparam int MAX_TILE    = 8;
   localparam int TILE_IDX_W  = 8;
   localparam int COLOR_W     = 32;
   localparam int MASK_W      = 64;
   localparam int SCREEN_W    = 12;
   localparam int CSR_INDEX_W = 1;
   localparam int QUEUE_DEPTH = 4;
   localparam int QUEUE_PTR_W = $clog2(QUEUE_DEPTH);

   localparam logic [CSR_INDEX_W-1:0] CSR_SCREEN_WIDTH  = 1'b0;
   localparam logic [CSR_INDEX_W-1:0] CSR_SCREEN_HEIGHT = 1'b1;

   localparam logic [SCREEN_W-1:0] SCREEN_WIDTH_RESET  = 12'd640;
   localparam logic [SCREEN_W-1:0] SCREEN_HEIGHT_RESET = 12'd480;

   typedef logic signed [COORD_W-1:0] coord_type;

   // edge function at the tile origin and its per-pixel steps
   typedef struct packed {
      logic signed [EDGE_W-1:0] origin;
      logic signed [DIFF_W-1:0] step_x;
      logic signed [DIFF_W-1:0] step_y;
      logic                     top_left;
   } edge_setup_type;

   typedef struct packed {
      edge_setup_type [NUM_EDGES-1:0] edges;
      logic [MAX_TILE-1:0]            col_ok;
      logic [MAX_TILE-1:0]            row_ok;
      logic [TILE_IDX_W-1:0]          tile_col;
      logic [TILE_IDX_W-1:0]          tile_row;
      logic [COLOR_W-1:0]             color;
   } tile_job_type;

endpackage

`default_nettype wire

>>> design/ttc_front.sv
// ttc_front: accepts triangles, computes edge setup and on-screen rows/columns
// two register stages; depends on ttc_pkg
`default_nettype none

module ttc_front #(
   parameter int TILE_SIZE = 8,
   parameter int PIX_W     = 11,
   parameter int LIM_W     = 12
) (
   input  wire                                              clock,
   input  wire                                              reset,
   input  wire                                              in_valid,
   output logic                                             in_stall,
   input  ttc_pkg::coord_type [ttc_pkg::NUM_EDGES-1:0]      vert_x,
   input  ttc_pkg::coord_type [ttc_pkg::NUM_EDGES-1:0]      vert_y,
   input  wire  [ttc_pkg::TILE_IDX_W-1:0]                   tile_col,
   input  wire  [ttc_pkg::TILE_IDX_W-1:0]                   tile_row,
   input  wire  [ttc_pkg::COLOR_W-1:0]                      color,
   input  wire  [LIM_W-1:0]                                 width_lim,
   input  wire  [LIM_W-1:0]                                 height_lim,
   output logic                                             out_valid,
   input  wire                                              out_stall,
   output ttc_pkg::tile_job_type                            out_job
);

   typedef struct packed {
      logic signed [ttc_pkg::DIFF_W-1:0] dx0;
      logic signed [ttc_pkg::DIFF_W-1:0] dy0;
      logic signed [ttc_pkg::DIFF_W-1:0] dx1;
      logic signed [ttc_pkg::DIFF_W-1:0] dy1;
      logic signed [ttc_pkg::DIFF_W-1:0] step_x;
      logic signed [ttc_pkg::DIFF_W-1:0] step_y;
      logic                              top_left;
   } edge_diff_type;

   logic                                     s1_valid_ff;
   logic                                     s2_valid_ff;
   logic                                     s1_en;
   logic                                     s2_en;
   edge_diff_type [ttc_pkg::NUM_EDGES-1:0]   diff_in;
   edge_diff_type [ttc_pkg::NUM_EDGES-1:0]   diff_ff;
   logic [ttc_pkg::MAX_TILE-1:0]             col_ok_in;
   logic [ttc_pkg::MAX_TILE-1:0]             row_ok_in;
   logic [ttc_pkg::MAX_TILE-1:0]             col_ok_ff;
   logic [ttc_pkg::MAX_TILE-1:0]             row_ok_ff;
   logic [ttc_pkg::TILE_IDX_W-1:0]           tile_col_ff;
   logic [ttc_pkg::TILE_IDX_W-1:0]           tile_row_ff;
   logic [ttc_pkg::COLOR_W-1:0]              color_ff;
   logic [PIX_W-1:0]                         px0;
   logic [PIX_W-1:0]                         py0;
   ttc_pkg::tile_job_type                    job_in;
   ttc_pkg::tile_job_type                    job_ff;

   assign s2_en    = !s2_valid_ff || !out_stall;
   assign s1_en    = !s1_valid_ff || s2_en;
   assign in_stall = !s1_en;

   assign px0 = PIX_W'(tile_col) * PIX_W'(TILE_SIZE);
   assign py0 = PIX_W'(tile_row) * PIX_W'(TILE_SIZE);

   // stage 1: vertex offsets from the tile origin and edge classification
   for (genvar e = 0; e < ttc_pkg::NUM_EDGES; e++) begin : g_edge
      localparam int NEXT = (e + 1) % ttc_pkg::NUM_EDGES;
      always_comb begin
         diff_in[e].dx0    = ttc_pkg::DIFF_W'(vert_x[e])
                             - $signed(ttc_pkg::DIFF_W'(px0));
         diff_in[e].dy0    = ttc_pkg::DIFF_W'(vert_y[e])
                             - $signed(ttc_pkg::DIFF_W'(py0));
         diff_in[e].dx1    = ttc_pkg::DIFF_W'(vert_x[NEXT])
                             - $signed(ttc_pkg::DIFF_W'(px0));
         diff_in[e].dy1    = ttc_pkg::DIFF_W'(vert_y[NEXT])
                             - $signed(ttc_pkg::DIFF_W'(py0));
         diff_in[e].step_x = ttc_pkg::DIFF_W'(vert_y[e]) - ttc_pkg::DIFF_W'(vert_y[NEXT]);
         diff_in[e].step_y = ttc_pkg::DIFF_W'(vert_x[NEXT]) - ttc_pkg::DIFF_W'(vert_x[e]);
         // top edge: horizontal toward smaller x; left edge: toward smaller y
         diff_in[e].top_left = ((vert_y[e] == vert_y[NEXT]) && (vert_x[e] > vert_x[NEXT]))
                               || (vert_y[e] > vert_y[NEXT]);
      end
   end

   always_comb begin
      col_ok_in = '0;
      row_ok_in = '0;
      for (int i = 0; i < TILE_SIZE; i++) begin
         col_ok_in[i] = (LIM_W'(px0) + LIM_W'(i)) < width_lim;
         row_ok_in[i] = (LIM_W'(py0) + LIM_W'(i)) < height_lim;
      end
   end

   // stage 2: edge function at the tile origin
   always_comb begin
      logic signed [ttc_pkg::EDGE_W-1:0] prod_a;
      logic signed [ttc_pkg::EDGE_W-1:0] prod_b;
      job_in = '0;
      for (int e = 0; e < ttc_pkg::NUM_EDGES; e++) begin
         prod_a = ttc_pkg::EDGE_W'(diff_ff[e].dx0) * ttc_pkg::EDGE_W'(diff_ff[e].dy1);
         prod_b = ttc_pkg::EDGE_W'(diff_ff[e].dx1) * ttc_pkg::EDGE_W'(diff_ff[e].dy0);
         job_in.edges[e].origin   = prod_a - prod_b;
         job_in.edges[e].step_x   = diff_ff[e].step_x;
         job_in.edges[e].step_y   = diff_ff[e].step_y;
         job_in.edges[e].top_left = diff_ff[e].top_left;
      end
      job_in.col_ok   = col_ok_ff;
      job_in.row_ok   = row_ok_ff;
      job_in.tile_col = tile_col_ff;
      job_in.tile_row = tile_row_ff;
      job_in.color    = color_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
         s2_valid_ff <= 1'b0;
      end else begin
         if (s1_en) begin
            s1_valid_ff <= in_valid;
         end
         if (s2_en) begin
            s2_valid_ff <= s1_valid_ff;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (s1_en && in_valid) begin
         diff_ff     <= diff_in;
         col_ok_ff   <= col_ok_in;
         row_ok_ff   <= row_ok_in;
         tile_col_ff <= tile_col;
         tile_row_ff <= tile_row;
         color_ff    <= color;
      end
      if (s2_en && s1_valid_ff) begin
         job_ff <= job_in;
      end
   end

   assign out_valid = s2_valid_ff;
   assign out_job   = job_ff;

endmodule

`default_nettype wire

>>> design/ttc_queue.sv
// ttc_queue: short fifo of set-up tile jobs between the front and back parts
// depends on ttc_pkg
`default_nettype none

module ttc_queue (
   input  wire                    clock,
   input  wire                    reset,
   input  wire                    in_valid,
   output logic                   in_stall,
   input  ttc_pkg::tile_job_type  in_job,
   output logic                   out_valid,
   input  wire                    out_stall,
   output ttc_pkg::tile_job_type  out_job
);

   ttc_pkg::tile_job_type             entries_ff [ttc_pkg::QUEUE_DEPTH];
   logic [ttc_pkg::QUEUE_PTR_W-1:0]   wr_ptr_ff;
   logic [ttc_pkg::QUEUE_PTR_W-1:0]   rd_ptr_ff;
   logic [ttc_pkg::QUEUE_PTR_W:0]     count_ff;
   logic [ttc_pkg::QUEUE_PTR_W:0]     count_in;
   logic                              push;
   logic                              pop;

   assign in_stall  = (count_ff == (ttc_pkg::QUEUE_PTR_W + 1)'(ttc_pkg::QUEUE_DEPTH));
   assign out_valid = (count_ff != '0);
   assign push      = in_valid && !in_stall;
   assign pop       = out_valid && !out_stall;
   assign out_job   = entries_ff[rd_ptr_ff];

   always_comb begin
      count_in = count_ff;
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         count_ff <= count_in;
         if (push) begin
            wr_ptr_ff <= wr_ptr_ff + 1'b1;
         end
         if (pop) begin
            rd_ptr_ff <= rd_ptr_ff + 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         entries_ff[wr_ptr_ff] <= in_job;
      end
   end

endmodule

`default_nettype wire

>>> design/ttc_back.sv
// ttc_back: expands edge setup over the tile and tests every pixel in parallel
// row bases and column steps, then the pixel array into the output register; uses ttc_pkg
`default_nettype none

module ttc_back #(
   parameter int TILE_SIZE = 8
) (
   input  wire                              clock,
   input  wire                              reset,
   input  wire                              in_valid,
   output logic                             in_stall,
   input  ttc_pkg::tile_job_type            in_job,
   output logic                             out_valid,
   input  wire                              out_stall,
   output logic [ttc_pkg::TILE_IDX_W-1:0]   out_tile_col,
   output logic [ttc_pkg::TILE_IDX_W-1:0]   out_tile_row,
   output logic [ttc_pkg::MASK_W-1:0]       out_mask,
   output logic [ttc_pkg::COLOR_W-1:0]      out_color
);

   localparam int NE = ttc_pkg::NUM_EDGES;

   logic                                s1_valid_ff;
   logic                                s2_valid_ff;
   logic                                s1_en;
   logic                                s2_en;
   logic signed [ttc_pkg::EDGE_W-1:0]   row_base_in [NE][TILE_SIZE];
   logic signed [ttc_pkg::EDGE_W-1:0]   row_base_ff [NE][TILE_SIZE];
   logic signed [ttc_pkg::EDGE_W-1:0]   col_step_in [NE][TILE_SIZE];
   logic signed [ttc_pkg::EDGE_W-1:0]   col_step_ff [NE][TILE_SIZE];
   logic [NE-1:0]                       top_left_ff;
   logic [ttc_pkg::MAX_TILE-1:0]        col_ok_ff;
   logic [ttc_pkg::MAX_TILE-1:0]        row_ok_ff;
   logic [ttc_pkg::TILE_IDX_W-1:0]      tile_col_ff;
   logic [ttc_pkg::TILE_IDX_W-1:0]      tile_row_ff;
   logic [ttc_pkg::COLOR_W-1:0]         color_ff;
   logic [ttc_pkg::MASK_W-1:0]          mask_in;
   logic [ttc_pkg::MASK_W-1:0]          mask_ff;
   logic [ttc_pkg::TILE_IDX_W-1:0]      out_tile_col_ff;
   logic [ttc_pkg::TILE_IDX_W-1:0]      out_tile_row_ff;
   logic [ttc_pkg::COLOR_W-1:0]         out_color_ff;

   assign s2_en    = !s2_valid_ff || !out_stall;
   assign s1_en    = !s1_valid_ff || s2_en;
   assign in_stall = !s1_en;

   // edge value at column 0 of each row, and offset of each column
   always_comb begin
      for (int e = 0; e < NE; e++) begin
         for (int i = 0; i < TILE_SIZE; i++) begin
            row_base_in[e][i] = in_job.edges[e].origin
                                + ttc_pkg::EDGE_W'(i)
                                  * ttc_pkg::EDGE_W'(in_job.edges[e].step_y);
            col_step_in[e][i] = ttc_pkg::EDGE_W'(i)
                                * ttc_pkg::EDGE_W'(in_job.edges[e].step_x);
         end
      end
   end

   always_comb begin
      logic signed [ttc_pkg::EDGE_W-1:0] sum;
      logic                              hit;
      mask_in = '0;
      for (int r = 0; r < TILE_SIZE; r++) begin
         for (int c = 0; c < TILE_SIZE; c++) begin
            hit = col_ok_ff[c] && row_ok_ff[r];
            for (int e = 0; e < NE; e++) begin
               sum = row_base_ff[e][r] + col_step_ff[e][c];
               // below zero always passes, zero only on a top or left edge
               hit = hit && (sum[ttc_pkg::EDGE_W-1] || (top_left_ff[e] && (sum == '0)));
            end
            mask_in[r * TILE_SIZE + c] = hit;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
         s2_valid_ff <= 1'b0;
      end else begin
         if (s1_en) begin
            s1_valid_ff <= in_valid;
         end
         if (s2_en) begin
            s2_valid_ff <= s1_valid_ff;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (s1_en && in_valid) begin
         row_base_ff <= row_base_in;
         col_step_ff <= col_step_in;
         for (int e = 0; e < NE; e++) begin
            top_left_ff[e] <= in_job.edges[e].top_left;
         end
         col_ok_ff   <= in_job.col_ok;
         row_ok_ff   <= in_job.row_ok;
         tile_col_ff <= in_job.tile_col;
         tile_row_ff <= in_job.tile_row;
         color_ff    <= in_job.color;
      end
      if (s2_en && s1_valid_ff) begin
         mask_ff         <= mask_in;
         out_tile_col_ff <= tile_col_ff;
         out_tile_row_ff <= tile_row_ff;
         out_color_ff    <= color_ff;
      end
   end

   assign out_valid    = s2_valid_ff;
   assign out_mask     = mask_ff;
   assign out_tile_col = out_tile_col_ff;
   assign out_tile_row = out_tile_row_ff;
   assign out_color    = out_color_ff;

endmodule

`default_nettype wire

>>> design/triangle_tile_coverage.sv
// triangle_tile_coverage: top level of the edge-function tile rasterizer
// instantiates ttc_front, ttc_queue and ttc_back; holds the screen size registers
`default_nettype none

//  channel   ports                      direction  beat
//  req       req_valid / req_stall      in         triangle, color, tile index
//  rsp       rsp_valid / rsp_stall      out        tile index, coverage mask, color
//  csr       csr_write_enable           in         screen width / height write
//
//  one tile per cycle sustained while rsp_stall is low; a beat reaches rsp through
//  the two setup stages (six 15x15 multipliers), the queue and two pixel stages
//  reset is synchronous: pipes and queue empty, screen back to 640 x 480
//  rsp_stall holds the back stages; the four-entry queue keeps req flowing until it fills

module triangle_tile_coverage #(
   parameter int TILE_SIZE = 8,
   parameter int MAX_DIM   = 2048
) (
   input  wire                                clock,
   input  wire                                reset,
   input  wire                                req_valid,
   output logic                               req_stall,
   input  wire  [ttc_pkg::COORD_W-1:0]        req_vertex_a_x,
   input  wire  [ttc_pkg::COORD_W-1:0]        req_vertex_a_y,
   input  wire  [ttc_pkg::COORD_W-1:0]        req_vertex_b_x,
   input  wire  [ttc_pkg::COORD_W-1:0]        req_vertex_b_y,
   input  wire  [ttc_pkg::COORD_W-1:0]        req_vertex_c_x,
   input  wire  [ttc_pkg::COORD_W-1:0]        req_vertex_c_y,
   input  wire  [ttc_pkg::COLOR_W-1:0]        req_fill_color,
   input  wire  [ttc_pkg::TILE_IDX_W-1:0]     req_tile_col,
   input  wire  [ttc_pkg::TILE_IDX_W-1:0]     req_tile_row,
   output logic                               rsp_valid,
   input  wire                                rsp_stall,
   output logic [ttc_pkg::TILE_IDX_W-1:0]     rsp_out_tile_col,
   output logic [ttc_pkg::TILE_IDX_W-1:0]     rsp_out_tile_row,
   output logic [ttc_pkg::MASK_W-1:0]         rsp_coverage_mask,
   output logic [ttc_pkg::COLOR_W-1:0]        rsp_out_color,
   output logic                               rsp_any_covered,
   input  wire                                csr_write_enable,
   input  wire  [ttc_pkg::CSR_INDEX_W-1:0]    csr_index,
   input  wire  [ttc_pkg::SCREEN_W-1:0]       csr_write_data
);

   localparam int PIX_W  = $clog2(256 * TILE_SIZE);
   localparam int DIM_W  = $clog2(MAX_DIM + 1);
   localparam int WIDE_W = (PIX_W > DIM_W) ? PIX_W : DIM_W;
   localparam int LIM_W  = (WIDE_W > ttc_pkg::SCREEN_W) ? WIDE_W : ttc_pkg::SCREEN_W;

   logic [ttc_pkg::SCREEN_W-1:0]                     screen_width_ff;
   logic [ttc_pkg::SCREEN_W-1:0]                     screen_height_ff;
   logic [LIM_W-1:0]                                 width_lim;
   logic [LIM_W-1:0]                                 height_lim;
   ttc_pkg::coord_type [ttc_pkg::NUM_EDGES-1:0]      vert_x;
   ttc_pkg::coord_type [ttc_pkg::NUM_EDGES-1:0]      vert_y;
   logic                                             front_valid;
   logic                                             front_stall;
   ttc_pkg::tile_job_type                            front_job;
   logic                                             queue_valid;
   logic                                             queue_stall;
   ttc_pkg::tile_job_type                            queue_job;

   always_ff @(posedge clock) begin
      if (reset) begin
         screen_width_ff  <= ttc_pkg::SCREEN_WIDTH_RESET;
         screen_height_ff <= ttc_pkg::SCREEN_HEIGHT_RESET;
      end else if (csr_write_enable) begin
         unique case (csr_index)
            ttc_pkg::CSR_SCREEN_WIDTH:  screen_width_ff  <= csr_write_data;
            ttc_pkg::CSR_SCREEN_HEIGHT: screen_height_ff <= csr_write_data;
            default: ;
         endcase
      end
   end

   // oversized screen dimensions clamp to the largest supported one
   assign width_lim  = (LIM_W'(screen_width_ff) > LIM_W'(MAX_DIM))
                       ? LIM_W'(MAX_DIM) : LIM_W'(screen_width_ff);
   assign height_lim = (LIM_W'(screen_height_ff) > LIM_W'(MAX_DIM))
                       ? LIM_W'(MAX_DIM) : LIM_W'(screen_height_ff);

   assign vert_x[0] = req_vertex_a_x;
   assign vert_y[0] = req_vertex_a_y;
   assign vert_x[1] = req_vertex_b_x;
   assign vert_y[1] = req_vertex_b_y;
   assign vert_x[2] = req_vertex_c_x;
   assign vert_y[2] = req_vertex_c_y;

   ttc_front #(
      .TILE_SIZE (TILE_SIZE),
      .PIX_W     (PIX_W),
      .LIM_W     (LIM_W)
   ) u_front (
      .clock      (clock),
      .reset      (reset),
      .in_valid   (req_valid),
      .in_stall   (req_stall),
      .vert_x     (vert_x),
      .vert_y     (vert_y),
      .tile_col   (req_tile_col),
      .tile_row   (req_tile_row),
      .color      (req_fill_color),
      .width_lim  (width_lim),
      .height_lim (height_lim),
      .out_valid  (front_valid),
      .out_stall  (front_stall),
      .out_job    (front_job)
   );

   ttc_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (front_valid),
      .in_stall  (front_stall),
      .in_job    (front_job),
      .out_valid (queue_valid),
      .out_stall (queue_stall),
      .out_job   (queue_job)
   );

   ttc_back #(
      .TILE_SIZE (TILE_SIZE)
   ) u_back (
      .clock        (clock),
      .reset        (reset),
      .in_valid     (queue_valid),
      .in_stall     (queue_stall),
      .in_job       (queue_job),
      .out_valid    (rsp_valid),
      .out_stall    (rsp_stall),
      .out_tile_col (rsp_out_tile_col),
      .out_tile_row (rsp_out_tile_row),
      .out_mask     (rsp_coverage_mask),
      .out_color    (rsp_out_color)
   );

   assign rsp_any_covered = |rsp_coverage_mask;

endmodule

`default_nettype wire

>>> design/ttc_checker.sv
// ttc_checker: port-level assertions for triangle_tile_coverage, bound to the top level
// depends on ttc_pkg for widths
`default_nettype none

module ttc_checker (
   input wire                              clock,
   input wire                              reset,
   input wire                              req_valid,
   input wire                              req_stall,
   input wire                              rsp_valid,
   input wire                              rsp_stall,
   input wire [ttc_pkg::TILE_IDX_W-1:0]    rsp_out_tile_col,
   input wire [ttc_pkg::TILE_IDX_W-1:0]    rsp_out_tile_row,
   input wire [ttc_pkg::MASK_W-1:0]        rsp_coverage_mask,
   input wire [ttc_pkg::COLOR_W-1:0]       rsp_out_color,
   input wire                              rsp_any_covered
);

   // nothing comes out of a pipe that reset just emptied
   a_reset_empties: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("rsp_valid high right after reset");

   a_rsp_holds: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_coverage_mask)
         && $stable(rsp_out_color) && $stable(rsp_out_tile_col)
         && $stable(rsp_out_tile_row))
      else $error("stalled rsp beat changed");

   a_any_matches_mask: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_any_covered == (rsp_coverage_mask != '0)))
      else $error("any_covered disagrees with mask");

   // the front is empty right out of reset, so req is never stalled then
   a_req_stall_sane: assert property (@(posedge clock) disable iff (reset)
      req_stall |-> !$past(reset))
      else $error("req_stall raised straight out of reset");

endmodule

bind triangle_tile_coverage ttc_checker u_ttc_checker (.*);

`default_nettype wire
